// ===== rtl/crc32_sample_etag_hash_assert.svh =====
// ---------------------------------------------------------------------------
// crc32_sample_etag_hash assertion macros
// clocked assertion helpers shared by the checker
// ---------------------------------------------------------------------------
`ifndef CRC32_SAMPLE_ETAG_HASH_ASSERT_SVH
`define CRC32_SAMPLE_ETAG_HASH_ASSERT_SVH

// property must hold at every clock edge outside reset
`define CE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/crcetag_pkg.sv =====
// ---------------------------------------------------------------------------
// crcetag_pkg
// types and constants shared by the crc32 sample tag hasher
// ---------------------------------------------------------------------------
package crcetag_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
    localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;
    localparam logic [31:0] ETAG_SEED = 32'hA5C3F19B;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // selects the round of the shared xorshift-multiply unit
    typedef struct packed {
        logic shift15;
        logic use_b;
    } mix_ctrl_t;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

endpackage

// ===== rtl/crcetag_fold.sv =====
// ---------------------------------------------------------------------------
// crcetag_fold
// folds one byte into a reflected crc-32 register
// ---------------------------------------------------------------------------
module crcetag_fold (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import crcetag_pkg::*;

    logic [31:0] r;

    always_comb
    begin
        r = crc_in ^ {24'b0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        crc_out = r;
    end

endmodule

// ===== rtl/crcetag_mixer.sv =====
// ---------------------------------------------------------------------------
// crcetag_mixer
// shared xorshift-multiply round of the 32-bit finalizer
// ---------------------------------------------------------------------------
module crcetag_mixer (
    input  logic [31:0]           v,
    input  crcetag_pkg::mix_ctrl_t ctrl,
    output logic [31:0]           y
);
    import crcetag_pkg::*;

    logic [31:0] shifted;
    logic [31:0] mult_k;

    assign shifted = ctrl.shift15 ? (v ^ (v >> 15)) : (v ^ (v >> 16));
    assign mult_k  = ctrl.use_b ? MIX_MUL_B : MIX_MUL_A;
    // low 32 bits of the product only
    assign y       = shifted * mult_k;

endmodule

// ===== rtl/crc32_sample_etag_hash.sv =====
// ---------------------------------------------------------------------------
// crc32_sample_etag_hash
// reflected crc-32 over sampled bytes, finished into a 32-bit entity tag
// ---------------------------------------------------------------------------
// An absorb transaction (cmd 0) folds data_byte into the running CRC, and
// the block is ready again on the next cycle, even while a tag is
// still waiting on the output. A finish transaction (cmd 1) produces
// etag = 0xA5C3F19B ^ mix(file_size) ^ mix(~crc) and returns the CRC to all
// ones. It holds the input off while a single 32x32 multiplier is used for
// four registered rounds (two per mix) and the tag is then written to the
// output register; if the previous tag has not been taken yet the block
// waits in that last step until it is.
module crc32_sample_etag_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [31:0] file_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] etag
);
    import crcetag_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE_A,
        S_SIZE_B,
        S_CRC_A,
        S_CRC_B,
        S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_hold_reg, crc_hold_next;
    logic [31:0] work_reg, work_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] etag_reg, etag_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] fold_out;
    logic [31:0] mix_in;
    logic [31:0] mix_out;
    mix_ctrl_t   mix_ctrl;

    crcetag_fold u_fold (
        .crc_in  (crc_reg),
        .data    (data_byte),
        .crc_out (fold_out)
    );

    assign mix_in           = (state_reg == S_CRC_A) ? crc_hold_reg : work_reg;
    assign mix_ctrl.shift15 = (state_reg == S_SIZE_B) || (state_reg == S_CRC_B);
    assign mix_ctrl.use_b   = (state_reg == S_SIZE_B) || (state_reg == S_CRC_B);

    crcetag_mixer u_mixer (
        .v    (mix_in),
        .ctrl (mix_ctrl),
        .y    (mix_out)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign etag      = etag_reg;

    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        crc_hold_next  = crc_hold_reg;
        work_next      = work_reg;
        acc_next       = acc_reg;
        etag_next      = etag_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_FINISH)
                    begin
                        work_next     = file_size;
                        crc_hold_next = ~crc_reg;
                        crc_next      = CRC_INIT;
                        state_next    = S_SIZE_A;
                    end
                    else
                        crc_next = fold_out;
                end
            end
            S_SIZE_A:
            begin
                work_next  = mix_out;
                state_next = S_SIZE_B;
            end
            S_SIZE_B:
            begin
                work_next  = mix_out;
                state_next = S_CRC_A;
            end
            S_CRC_A:
            begin
                // size mix completes here, crc mix starts
                acc_next   = ETAG_SEED ^ xs16(work_reg);
                work_next  = mix_out;
                state_next = S_CRC_B;
            end
            S_CRC_B:
            begin
                work_next  = mix_out;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    etag_next      = acc_reg ^ xs16(work_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            crc_reg       <= CRC_INIT;
            crc_hold_reg  <= '0;
            work_reg      <= '0;
            acc_reg       <= '0;
            etag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            crc_hold_reg  <= crc_hold_next;
            work_reg      <= work_next;
            acc_reg       <= acc_next;
            etag_reg      <= etag_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/crcetag_checker.sv =====
// ---------------------------------------------------------------------------
// crcetag_checker
// port-level checks of the crc32 sample tag hasher, bound to the top level
// ---------------------------------------------------------------------------
`include "crc32_sample_etag_hash_assert.svh"

module crcetag_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] etag
);
    import crcetag_pkg::*;

    logic fin_acc;

    assign fin_acc = in_valid && in_ready && (cmd == CMD_FINISH);

    // a waiting tag holds until taken
    `CE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(etag), "etag changed while stalled")

    // finish transaction occupies the block
    `CE_ASSERT(a_fin_busy, clk, rst_n, fin_acc |=> !in_ready, "ready right after finish transaction")

    // with the output free, the tag follows the four mix rounds and the emit step
    `CE_ASSERT(a_fin_latency, clk, rst_n, fin_acc && !out_valid |-> ##6 out_valid, "tag not produced in time")

    // a new tag is only loaded on the way back to idle
    `CE_NEVER(a_rise_ready, clk, rst_n, $rose(out_valid) && !in_ready, "tag loaded while busy")

endmodule

bind crc32_sample_etag_hash crcetag_checker u_crcetag_checker (.*);
